>>> src/rwbs_pkg.sv
// Shared types and constants for the row-wise binary search block.
package rwbs_pkg;

	localparam int ROWS       = 8;
	localparam int COLS       = 16;
	localparam int KEY_WIDTH  = 32;
	localparam int DEPTH      = ROWS * COLS;
	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W      = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int CNT_W      = $clog2(COLS + 1);
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CFG_ROWS_W = 4;
	localparam int CFG_COLS_W = 5;
	localparam int CFG_DATA_W = 8;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef enum logic {
		REG_ROWS_IN_USE = 1'b0,
		REG_COLS_IN_USE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW,
		ST_PROBE,
		ST_CMP
	} seq_state_t;

	typedef struct packed {
		op_t                           operation;
		logic [ROW_W-1:0]              row_select;
		logic [COL_W-1:0]              column_select;
		logic signed [KEY_WIDTH-1:0]   key_value;
	} cmd_t;

	typedef struct packed {
		logic [ROW_W-1:0] result_row;
		logic             hit;
		logic [COL_W-1:0] hit_column;
		logic             last_row;
	} result_t;

	typedef struct packed {
		logic [CFG_ROWS_W-1:0] rows_in_use;
		logic [CFG_COLS_W-1:0] cols_in_use;
	} cfg_t;

	typedef struct packed {
		logic                  en;
		logic [ADDR_W-1:0]     addr;
		logic [KEY_WIDTH-1:0]  data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

endpackage

>>> src/rwbs_cfg.sv
// Configuration registers: rows and columns in use.
module rwbs_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  rwbs_pkg::reg_idx_t             cfg_index,
	input  logic [rwbs_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           cfg_ready,
	output rwbs_pkg::cfg_t                 cfg
);
	import rwbs_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows_in_use <= CFG_ROWS_W'(ROWS);
			cfg_q.cols_in_use <= CFG_COLS_W'(COLS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROWS_IN_USE: cfg_q.rows_in_use <= cfg_data[CFG_ROWS_W-1:0];
				REG_COLS_IN_USE: cfg_q.cols_in_use <= cfg_data[CFG_COLS_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> src/rwbs_store.sv
// Matrix memory with one write port and one registered read port.
module rwbs_store (
	input  logic                            clk,
	input  rwbs_pkg::wr_req_t               wr,
	input  rwbs_pkg::rd_req_t               rd,
	output logic [rwbs_pkg::KEY_WIDTH-1:0]  rd_data
);
	import rwbs_pkg::*;

	logic [KEY_WIDTH-1:0] mem_q [DEPTH];
	logic [KEY_WIDTH-1:0] rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

endmodule

>>> src/rwbs_seq.sv
// Search sequencer: bounds, midpoint, shared key compare and result register.
module rwbs_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic signed [rwbs_pkg::KEY_WIDTH-1:0] key,
	input  rwbs_pkg::cfg_t                      cfg,
	output rwbs_pkg::rd_req_t                   rd,
	input  logic [rwbs_pkg::KEY_WIDTH-1:0]      rd_data,
	output logic                                busy,
	output logic                                res_valid,
	output rwbs_pkg::result_t                   res
);
	import rwbs_pkg::*;

	seq_state_t                  state_q, state_d;
	logic [ROW_W-1:0]            row_q, last_q;
	logic [CNT_W-1:0]            ncols_q;
	logic signed [CNT_W:0]       low_q, high_q;
	logic [COL_W-1:0]            mid_q;
	logic signed [KEY_WIDTH-1:0] target_q;
	logic                        res_valid_q;
	result_t                     res_q;

	logic                        in_range;
	logic [CNT_W:0]              bound_sum;
	logic [COL_W-1:0]            mid_w;
	logic                        eq, gt;
	logic                        emit, hit_w, is_last;
	logic [CFG_ROWS_W-1:0]       rows_sat;
	logic [CNT_W-1:0]            cols_sat;
	logic signed [CNT_W:0]       mid_ext;

	assign in_range  = (low_q <= high_q);
	assign bound_sum = $unsigned(low_q) + $unsigned(high_q);
	assign mid_w     = COL_W'(bound_sum >> 1);
	assign eq        = ($signed(rd_data) == target_q);
	assign gt        = (target_q > $signed(rd_data));
	assign is_last   = (row_q == last_q);
	assign mid_ext   = $signed({{(CNT_W + 1 - COL_W){1'b0}}, mid_q});

	always_comb begin
		rows_sat = cfg.rows_in_use;
		if (cfg.rows_in_use == '0) begin
			rows_sat = CFG_ROWS_W'(1);
		end else if (int'(cfg.rows_in_use) > ROWS) begin
			rows_sat = CFG_ROWS_W'(ROWS);
		end
		cols_sat = CNT_W'(cfg.cols_in_use);
		if (int'(cfg.cols_in_use) > COLS) begin
			cols_sat = CNT_W'(COLS);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (go) state_d = ST_ROW;
			end
			ST_ROW: state_d = ST_PROBE;
			ST_PROBE: begin
				if (in_range) state_d = ST_CMP;
				else          state_d = is_last ? ST_IDLE : ST_ROW;
			end
			ST_CMP: begin
				if (eq) state_d = is_last ? ST_IDLE : ST_ROW;
				else    state_d = ST_PROBE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd.en   = (state_q == ST_PROBE) && in_range;
		rd.addr = ADDR_W'(int'(row_q) * COLS) + ADDR_W'(mid_w);
		emit    = ((state_q == ST_PROBE) && !in_range) || ((state_q == ST_CMP) && eq);
		hit_w   = (state_q == ST_CMP) && eq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			last_q      <= '0;
			ncols_q     <= '0;
			low_q       <= '0;
			high_q      <= '0;
			mid_q       <= '0;
			target_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= emit;
			if ((state_q == ST_IDLE) && go) begin
				target_q <= key;
				last_q   <= ROW_W'(rows_sat - 1'b1);
				ncols_q  <= cols_sat;
				row_q    <= '0;
			end
			if (state_q == ST_ROW) begin
				low_q  <= '0;
				high_q <= $signed({1'b0, ncols_q}) - (CNT_W + 1)'(1);
			end
			if (rd.en) begin
				mid_q <= mid_w;
			end
			if ((state_q == ST_CMP) && !eq) begin
				if (gt) high_q <= mid_ext - (CNT_W + 1)'(1);
				else    low_q  <= mid_ext + (CNT_W + 1)'(1);
			end
			if (emit && !is_last) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.result_row <= row_q;
			res_q.hit        <= hit_w;
			res_q.hit_column <= hit_w ? mid_q : '0;
			res_q.last_row   <= is_last;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> src/row_wise_binary_search_top.sv
// Top level of the row-wise binary search block.
// Write: stored in the matrix, busy stays low. Search: per row a setup state, then per probe a memory
// read state and a compare state, and a closing probe state on a miss; the matrix holds 8 x 16 entries.
// The single memory read port and shared compare set the search time; busy is high throughout.
// Each row's result is registered and arrives in the cycle after the row finishes; it cannot be stalled.
// Reset clears the sequencer, sets rows_in_use to 8 and cols_in_use to 16; matrix not cleared.
module row_wise_binary_search_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  rwbs_pkg::cmd_t                   cmd,
	output logic                             busy,
	output logic                             result_valid,
	output rwbs_pkg::result_t                result,
	input  logic                             cfg_valid,
	input  rwbs_pkg::reg_idx_t               cfg_index,
	input  logic [rwbs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                             cfg_ready
);
	import rwbs_pkg::*;

	logic                 accept;
	logic                 go;
	cfg_t                 cfg;
	wr_req_t              wr;
	rd_req_t              rd;
	logic [KEY_WIDTH-1:0] rd_data;

	assign accept = start && !busy;
	assign go     = accept && (cmd.operation == OP_SEARCH);

	always_comb begin
		wr.en   = accept && (cmd.operation == OP_WRITE)
			&& (int'(cmd.row_select) < ROWS) && (int'(cmd.column_select) < COLS);
		wr.addr = ADDR_W'(int'(cmd.row_select) * COLS) + ADDR_W'(cmd.column_select);
		wr.data = cmd.key_value;
	end

	rwbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	rwbs_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	rwbs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.key       (cmd.key_value),
		.cfg       (cfg),
		.rd        (rd),
		.rd_data   (rd_data),
		.busy      (busy),
		.res_valid (result_valid),
		.res       (result)
	);

endmodule

>>> src/rwbs_checker.sv
// Port-level checks for the row-wise binary search block, bound to the top level.
module rwbs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input rwbs_pkg::cmd_t    cmd,
	input logic              busy,
	input logic              result_valid,
	input rwbs_pkg::result_t result
);
	import rwbs_pkg::*;

	a_result_during_search: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a search in progress");

	a_search_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.operation == OP_SEARCH) |=> busy)
		else $error("search transfer did not raise busy");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.operation == OP_WRITE) |=> !result_valid)
		else $error("write transfer produced a result");

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_row) |=> !result_valid)
		else $error("result strobe right after the last row");

	a_miss_column_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.hit) |-> (result.hit_column == '0))
		else $error("miss reported with nonzero column");

endmodule

bind row_wise_binary_search_top rwbs_checker u_rwbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.cmd          (cmd),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
